>>> hw/rtl/asm_pkg.sv
// Shared types and sizes for the axis segment merger.
// Holds the port payload structs and the stored entry format.
// No dependencies.
package asm_pkg;
    localparam int MAX_SEGMENTS  = 256;
    localparam int MAX_OUT_LINES = 32;
    localparam int COORD_BITS    = 12;
    localparam int ADDR_BITS     = $clog2(MAX_SEGMENTS);
    localparam int CNT_BITS      = ADDR_BITS + 1;
    localparam int LIM_BITS      = 6;

    localparam logic [1:0] REG_TOLERANCE = 2'd0;
    localparam logic [1:0] REG_GAP       = 2'd1;
    localparam logic [1:0] REG_MAX_LINES = 2'd2;

    typedef struct packed {
        logic [COORD_BITS-1:0] seg_coord;
        logic [COORD_BITS-1:0] seg_start;
        logic [COORD_BITS-1:0] seg_end;
        logic                  seg_last;
    } seg_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] line_coord;
        logic [COORD_BITS-1:0] line_start;
        logic [COORD_BITS-1:0] line_end;
        logic                  line_last;
    } line_out_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] coord;
        logic [COORD_BITS-1:0] lo;
        logic [COORD_BITS-1:0] hi;
    } entry_t;
endpackage

>>> hw/rtl/axis_segment_merger.sv
// Axis segment merger top level: segment store, line store and sequencer.
// Depends on asm_pkg.
//
// Usage: pulse start with a segment on seg while busy is low; one segment
// transfer per cycle is taken until one with seg_last set. busy then rises
// and the set is sorted (insertion sort in the segment store), merged
// (each segment scans all lines built so far in the line store, one entry
// per cycle), sorted longest first, cut to the line limit and sorted by
// coordinate. Each sort step is one read of the single-port-read store.
// The lines then leave on line, one per cycle, each marked by valid for
// one cycle; the receiver cannot stall, so it must take every transfer.
// busy falls with the final line. Configuration is written through
// cfg_we / cfg_index / cfg_data while idle. Reset returns to idle with
// empty stores and the default tolerance 6, gap 8 and line limit 32; no
// clearing pass is run.
module axis_segment_merger
    import asm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  seg_in_t         seg,
    output logic            valid,
    output line_out_t       line,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [7:0]      cfg_data
);
    typedef enum logic [11:0] {
        ST_IDLE    = 12'b000000000001,
        ST_SINIT   = 12'b000000000010,
        ST_SRDKEY  = 12'b000000000100,
        ST_SKEY    = 12'b000000001000,
        ST_SCMP    = 12'b000000010000,
        ST_SPUT    = 12'b000000100000,
        ST_MRDS    = 12'b000001000000,
        ST_MSEG    = 12'b000010000000,
        ST_MSCAN   = 12'b000100000000,
        ST_MWR     = 12'b001000000000,
        ST_ERD     = 12'b010000000000,
        ST_EOUT    = 12'b100000000000
    } state_t;

    typedef enum logic [1:0] {
        SM_SEG = 2'd0,
        SM_LEN = 2'd1,
        SM_CRD = 2'd2
    } smode_t;

    state_t state_reg, state_next;
    smode_t mode_reg, mode_next;
    logic [CNT_BITS-1:0] seg_cnt_reg, seg_cnt_next;
    logic [CNT_BITS-1:0] mc_reg, mc_next;
    logic [CNT_BITS-1:0] i_reg, i_next;
    logic [CNT_BITS-1:0] j_reg, j_next;
    logic [CNT_BITS-1:0] n_reg, n_next;
    logic [CNT_BITS-1:0] s_reg, s_next;
    logic [ADDR_BITS-1:0] best_reg, best_next;
    logic [8:0] bd_reg, bd_next;
    logic found_reg, found_next;
    entry_t key_reg, key_next;
    entry_t bdata_reg, bdata_next;
    entry_t g_reg, g_next;
    logic [7:0] tol_reg, gap_reg;
    logic [LIM_BITS-1:0] maxl_reg;
    line_out_t out_reg, out_next;
    logic valid_reg, valid_next;

    entry_t seg_mem [MAX_SEGMENTS];
    entry_t line_mem [MAX_SEGMENTS];
    entry_t seg_rd_reg, line_rd_reg;
    logic [ADDR_BITS-1:0] seg_ra, line_ra, seg_wa, line_wa;
    logic seg_we, line_we;
    entry_t seg_wd, line_wd;

    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[seg_wa] <= seg_wd;
        end
        seg_rd_reg <= seg_mem[seg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_wa] <= line_wd;
        end
        line_rd_reg <= line_mem[line_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg  <= 8'd6;
            gap_reg  <= 8'd8;
            maxl_reg <= LIM_BITS'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOLERANCE: tol_reg  <= cfg_data;
                REG_GAP:       gap_reg  <= cfg_data;
                REG_MAX_LINES: maxl_reg <= cfg_data[LIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // helpers
    entry_t in_e, srt_rd, m_e;
    logic [CNT_BITS-1:0] jm1, jm2, ip1, im1;
    logic key_first, fin, qual;
    logic [COORD_BITS-1:0] cdist, klen, plen;
    logic [COORD_BITS:0] csum;
    logic [LIM_BITS-1:0] lim;

    always_comb
    begin
        in_e.coord = seg.seg_coord;
        in_e.lo = (seg.seg_end < seg.seg_start) ? seg.seg_end : seg.seg_start;
        in_e.hi = (seg.seg_end < seg.seg_start) ? seg.seg_start : seg.seg_end;
        srt_rd = (mode_reg == SM_SEG) ? seg_rd_reg : line_rd_reg;
        jm1 = j_reg - CNT_BITS'(1);
        jm2 = j_reg - CNT_BITS'(2);
        ip1 = i_reg + CNT_BITS'(1);
        im1 = i_reg - CNT_BITS'(1);
        klen = key_reg.hi - key_reg.lo;
        plen = srt_rd.hi - srt_rd.lo;
        case (mode_reg)
            SM_SEG:  key_first = (key_reg.coord != srt_rd.coord) ?
                                 (key_reg.coord < srt_rd.coord) :
                                 (key_reg.lo != srt_rd.lo) ? (key_reg.lo < srt_rd.lo) :
                                 (key_reg.hi < srt_rd.hi);
            SM_LEN:  key_first = klen > plen;
            SM_CRD:  key_first = key_reg.coord < srt_rd.coord;
            default: key_first = 1'b0;
        endcase
        m_e = line_rd_reg;
        cdist = (m_e.coord > g_reg.coord) ? m_e.coord - g_reg.coord
                                          : g_reg.coord - m_e.coord;
        qual = (cdist <= {4'd0, tol_reg})
            && ({1'b0, g_reg.lo} <= {1'b0, m_e.hi} + {5'd0, gap_reg})
            && ({1'b0, m_e.lo} <= {1'b0, g_reg.hi} + {5'd0, gap_reg})
            && (cdist < {3'd0, bd_reg});
        csum = {1'b0, bdata_reg.coord} + {1'b0, g_reg.coord};
        if (maxl_reg == '0)
            lim = LIM_BITS'(1);
        else if (maxl_reg > LIM_BITS'(MAX_OUT_LINES))
            lim = LIM_BITS'(MAX_OUT_LINES);
        else
            lim = maxl_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        seg_cnt_next = seg_cnt_reg;
        mc_next = mc_reg;
        i_next = i_reg;
        j_next = j_reg;
        n_next = n_reg;
        s_next = s_reg;
        best_next = best_reg;
        bd_next = bd_reg;
        found_next = found_reg;
        key_next = key_reg;
        bdata_next = bdata_reg;
        g_next = g_reg;
        out_next = out_reg;
        valid_next = 1'b0;
        fin = 1'b0;
        seg_ra = '0;
        line_ra = '0;
        seg_we = 1'b0;
        line_we = 1'b0;
        seg_wa = seg_cnt_reg[ADDR_BITS-1:0];
        line_wa = j_reg[ADDR_BITS-1:0];
        seg_wd = in_e;
        line_wd = key_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (seg_cnt_reg < CNT_BITS'(MAX_SEGMENTS))
                    begin
                        seg_we = 1'b1;
                        seg_cnt_next = seg_cnt_reg + CNT_BITS'(1);
                    end
                    if (seg.seg_last)
                    begin
                        n_next = seg_cnt_next;
                        mode_next = SM_SEG;
                        state_next = ST_SINIT;
                    end
                end
            end
            ST_SINIT:
            begin
                i_next = CNT_BITS'(1);
                if (n_reg <= CNT_BITS'(1))
                    fin = 1'b1;
                else
                    state_next = ST_SRDKEY;
            end
            ST_SRDKEY:
            begin
                seg_ra = i_reg[ADDR_BITS-1:0];
                line_ra = i_reg[ADDR_BITS-1:0];
                state_next = ST_SKEY;
            end
            ST_SKEY:
            begin
                key_next = srt_rd;
                j_next = i_reg;
                seg_ra = im1[ADDR_BITS-1:0];
                line_ra = im1[ADDR_BITS-1:0];
                state_next = ST_SCMP;
            end
            ST_SCMP:
            begin
                seg_wa = j_reg[ADDR_BITS-1:0];
                if (key_first)
                begin
                    seg_wd = srt_rd;
                    line_wd = srt_rd;
                    j_next = jm1;
                    seg_ra = jm2[ADDR_BITS-1:0];
                    line_ra = jm2[ADDR_BITS-1:0];
                    if (jm1 == '0)
                        state_next = ST_SPUT;
                end
                else
                begin
                    seg_wd = key_reg;
                    i_next = ip1;
                    if (ip1 < n_reg)
                        state_next = ST_SRDKEY;
                    else
                        fin = 1'b1;
                end
                seg_we = (mode_reg == SM_SEG);
                line_we = (mode_reg != SM_SEG);
            end
            ST_SPUT:
            begin
                seg_wa = j_reg[ADDR_BITS-1:0];
                seg_wd = key_reg;
                seg_we = (mode_reg == SM_SEG);
                line_we = (mode_reg != SM_SEG);
                i_next = ip1;
                if (ip1 < n_reg)
                    state_next = ST_SRDKEY;
                else
                    fin = 1'b1;
            end
            ST_MRDS:
            begin
                seg_ra = s_reg[ADDR_BITS-1:0];
                state_next = ST_MSEG;
            end
            ST_MSEG:
            begin
                g_next = seg_rd_reg;
                i_next = '0;
                found_next = 1'b0;
                bd_next = {1'b0, tol_reg} + 9'd1;
                line_ra = '0;
                state_next = (mc_reg == '0) ? ST_MWR : ST_MSCAN;
            end
            ST_MSCAN:
            begin
                if (qual)
                begin
                    best_next = i_reg[ADDR_BITS-1:0];
                    bd_next = cdist[8:0];
                    found_next = 1'b1;
                    bdata_next = m_e;
                end
                if (ip1 < mc_reg)
                begin
                    line_ra = ip1[ADDR_BITS-1:0];
                    i_next = ip1;
                end
                else
                    state_next = ST_MWR;
            end
            ST_MWR:
            begin
                line_we = 1'b1;
                if (!found_reg)
                begin
                    line_wa = mc_reg[ADDR_BITS-1:0];
                    line_wd = g_reg;
                    mc_next = mc_reg + CNT_BITS'(1);
                end
                else
                begin
                    line_wa = best_reg;
                    line_wd.coord = csum[COORD_BITS:1];
                    line_wd.lo = (g_reg.lo < bdata_reg.lo) ? g_reg.lo : bdata_reg.lo;
                    line_wd.hi = (g_reg.hi > bdata_reg.hi) ? g_reg.hi : bdata_reg.hi;
                end
                s_next = s_reg + CNT_BITS'(1);
                if (s_next < seg_cnt_reg)
                    state_next = ST_MRDS;
                else
                begin
                    mode_next = SM_LEN;
                    n_next = mc_next;
                    state_next = ST_SINIT;
                end
            end
            ST_ERD:
            begin
                line_ra = '0;
                i_next = '0;
                state_next = ST_EOUT;
            end
            ST_EOUT:
            begin
                valid_next = 1'b1;
                out_next.line_coord = line_rd_reg.coord;
                out_next.line_start = line_rd_reg.lo;
                out_next.line_end = line_rd_reg.hi;
                out_next.line_last = (ip1 == n_reg);
                if (ip1 < n_reg)
                begin
                    line_ra = ip1[ADDR_BITS-1:0];
                    i_next = ip1;
                end
                else
                begin
                    state_next = ST_IDLE;
                    seg_cnt_next = '0;
                    mc_next = '0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (fin)
        begin
            case (mode_reg)
                SM_SEG:
                begin
                    s_next = '0;
                    mc_next = '0;
                    state_next = ST_MRDS;
                end
                SM_LEN:
                begin
                    mode_next = SM_CRD;
                    n_next = (mc_reg < CNT_BITS'(lim)) ? mc_reg : CNT_BITS'(lim);
                    state_next = ST_SINIT;
                end
                default: state_next = ST_ERD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mode_reg    <= SM_SEG;
            seg_cnt_reg <= '0;
            mc_reg      <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            s_reg       <= '0;
            found_reg   <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            seg_cnt_reg <= seg_cnt_next;
            mc_reg      <= mc_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            n_reg       <= n_next;
            s_reg       <= s_next;
            found_reg   <= found_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg  <= best_next;
        bd_reg    <= bd_next;
        key_reg   <= key_next;
        bdata_reg <= bdata_next;
        g_reg     <= g_next;
        out_reg   <= out_next;
    end

    assign busy  = (state_reg != ST_IDLE);
    assign valid = valid_reg;
    assign line  = out_reg;

`ifndef SYNTHESIS
    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && seg.seg_last |=> busy)
        else $error("set close did not start processing");
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && line.line_last |=> !valid)
        else $error("transfer after final line");
    a_lines_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        mc_reg <= seg_cnt_reg)
        else $error("more lines than segments");
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seg_cnt_reg <= CNT_BITS'(MAX_SEGMENTS))
        else $error("segment count overflow");
`endif
endmodule
